// ===== hdl/iorq_pkg.sv =====
// ----------------------------------------------------------------------------
// iorq_pkg: shared types and codes for the in-order response queue
// Request and result payloads, mode and status codes, store commands and
// sequencer states.
// ----------------------------------------------------------------------------
package iorq_pkg;

	localparam int TAG_W       = 16;
	localparam int RESP_W      = 16;
	localparam int MAX_RESULTS = 16;
	localparam int NOUT_W      = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] MODE_ENQ    = 2'd0;
	localparam logic [1:0] MODE_ATTACH = 2'd1;
	localparam logic [1:0] MODE_DRAIN  = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_MISS = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TAG_W-1:0]  request_tag;
		logic              is_head_method;
		logic [RESP_W-1:0] response_handle;
	} req_t;

	typedef struct packed {
		logic              item_valid;
		logic [RESP_W-1:0] out_response;
		logic              out_head_method;
		logic              at_front;
		logic [1:0]        status;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic enq;
		logic attach;
		logic retire;
	} store_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SCAN_ADDR,
		ST_SCAN_CMP,
		ST_ATTACH,
		ST_MISS,
		ST_NOP,
		ST_DRAIN_CHK,
		ST_DRAIN_OUT
	} state_t;

endpackage

// ===== hdl/iorq_store.sv =====
// ----------------------------------------------------------------------------
// iorq_store: entry storage
// Tag, head flag and response memories with registered reads, plus the
// per-entry ready bits.
// ----------------------------------------------------------------------------
module iorq_store #(
	parameter int DEPTH = 16,
	parameter int TW    = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  iorq_pkg::store_cmd_t     cmd,
	input  logic [AW-1:0]            wr_addr,
	input  logic [TW-1:0]            wr_tag,
	input  logic                     wr_head,
	input  logic [iorq_pkg::RESP_W-1:0] wr_resp,
	input  logic [AW-1:0]            rd_addr,
	output logic [TW-1:0]            rd_tag,
	output logic                     rd_head,
	output logic [iorq_pkg::RESP_W-1:0] rd_resp,
	output logic [DEPTH-1:0]         ready_vec
);
	import iorq_pkg::*;

	logic [TW-1:0]     tag_mem  [DEPTH];
	logic              head_mem [DEPTH];
	logic [RESP_W-1:0] resp_mem [DEPTH];
	logic [TW-1:0]     rd_tag_q;
	logic              rd_head_q;
	logic [RESP_W-1:0] rd_resp_q;
	logic [DEPTH-1:0]  ready_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			tag_mem[wr_addr]  <= wr_tag;
			head_mem[wr_addr] <= wr_head;
		end
		if (cmd.attach) begin
			resp_mem[wr_addr] <= wr_resp;
		end
		rd_tag_q  <= tag_mem[rd_addr];
		rd_head_q <= head_mem[rd_addr];
		rd_resp_q <= resp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else begin
			if (cmd.enq || cmd.retire) begin
				ready_q[wr_addr] <= 1'b0;
			end else if (cmd.attach) begin
				ready_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_tag    = rd_tag_q;
	assign rd_head   = rd_head_q;
	assign rd_resp   = rd_resp_q;
	assign ready_vec = ready_q;

endmodule

// ===== hdl/iorq_walk.sv =====
// ----------------------------------------------------------------------------
// iorq_walk: shared slot and compare unit
// Circular slot index from a base and an offset, and the tag comparator
// used one entry per step by the sequencer.
// ----------------------------------------------------------------------------
module iorq_walk #(
	parameter int DEPTH = 16,
	parameter int TW    = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic [AW-1:0] base,
	input  logic [AW-1:0] offset,
	input  logic [TW-1:0] key,
	input  logic [TW-1:0] tag,
	output logic [AW-1:0] slot,
	output logic          match
);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

	logic [AW:0] sum;
	logic [AW:0] wrapped;

	assign sum     = {1'b0, base} + {1'b0, offset};
	assign wrapped = sum - DEPTH_W;
	assign slot    = (sum >= DEPTH_W) ? wrapped[AW-1:0] : sum[AW-1:0];
	assign match   = (key == tag);

endmodule

// ===== hdl/in_order_response_queue.sv =====
// ----------------------------------------------------------------------------
// in_order_response_queue: reorder queue for pipelined requests
// Keeps request tags in arrival order and releases attached responses in
// that same order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): mode 0 enqueues a tag and head
//   flag, mode 1 attaches a response handle to the oldest matching tag,
//   mode 2 drains ready entries from the front (up to 16 per request).
//   rsp channel (rsp_valid/rsp_stall/rsp): one result for enqueue, attach
//   and unused mode; one result per drained entry, or one empty result if
//   the front entry is not ready. last marks the final result of a request.
//   A request is taken only while the sequencer is idle; one request at a
//   time. Enqueue and unused mode go from their state straight to the
//   output register. Attach walks the entries from the front, each with a
//   tag memory read and then a compare, and ends with an attach on a hit
//   or a miss result once all entries are compared; drain reads the
//   response memory once per entry drained, before each drained result.
//   The output register lets the next request be accepted while the last
//   result is still waiting. A stalled result holds; the sequencer waits.
//   Reset empties the queue and clears all ready bits; no clearing pass.
// ----------------------------------------------------------------------------
module in_order_response_queue #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  iorq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output iorq_pkg::rsp_t rsp
);
	import iorq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam logic [CW-1:0]     FULL_COUNT = CW'(DEPTH);
	localparam logic [NOUT_W-1:0] NOUT_LAST  = NOUT_W'(MAX_RESULTS - 1);

	state_t            state_q, state_d;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     off_q;
	logic [AW-1:0]     slot_q;
	logic [TW-1:0]     key_q;
	logic              head_q;
	logic [RESP_W-1:0] resp_q;
	logic [NOUT_W-1:0] nout_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              out_free;
	logic              emit;
	rsp_t              res;
	store_cmd_t        cmd;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     walk_off;
	logic [AW-1:0]     slot;
	logic              match;
	logic [TW-1:0]     rd_tag;
	logic              rd_head;
	logic [RESP_W-1:0] rd_resp;
	logic [DEPTH-1:0]  ready_vec;
	logic              drain_go;
	logic              drain_last;

	iorq_store #(.DEPTH(DEPTH), .TW(TW)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.wr_tag    (key_q),
		.wr_head   (head_q),
		.wr_resp   (resp_q),
		.rd_addr   (rd_addr),
		.rd_tag    (rd_tag),
		.rd_head   (rd_head),
		.rd_resp   (rd_resp),
		.ready_vec (ready_vec)
	);

	iorq_walk #(.DEPTH(DEPTH), .TW(TW)) u_walk (
		.base   (front_q),
		.offset (walk_off),
		.key    (key_q),
		.tag    (rd_tag),
		.slot   (slot),
		.match  (match)
	);

	assign out_free   = !out_valid_q || !rsp_stall;
	assign drain_go   = (count_q != '0) && ready_vec[front_q];
	assign drain_last = (count_q == CW'(1)) || (nout_q == NOUT_LAST) || !ready_vec[slot];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req.mode)
						MODE_ENQ:    state_d = ST_ENQ;
						MODE_ATTACH: state_d = ST_SCAN_ADDR;
						MODE_DRAIN:  state_d = ST_DRAIN_CHK;
						default:     state_d = ST_NOP;
					endcase
				end
			end
			ST_ENQ, ST_ATTACH, ST_MISS, ST_NOP: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN_ADDR: begin
				state_d = (off_q == count_q) ? ST_MISS : ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				state_d = match ? ST_ATTACH : ST_SCAN_ADDR;
			end
			ST_DRAIN_CHK: begin
				if (drain_go) state_d = ST_DRAIN_OUT;
				else if (out_free) state_d = ST_IDLE;
			end
			ST_DRAIN_OUT: begin
				if (out_free) state_d = drain_last ? ST_IDLE : ST_DRAIN_CHK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		res      = '0;
		cmd      = '0;
		wr_addr  = front_q;
		rd_addr  = front_q;
		walk_off = '0;
		unique case (state_q)
			ST_ENQ: begin
				walk_off = count_q[AW-1:0];
				wr_addr  = slot;
				if (out_free) begin
					emit     = 1'b1;
					res.last = 1'b1;
					if (count_q == FULL_COUNT) res.status = STATUS_FULL;
					else cmd.enq = 1'b1;
				end
			end
			ST_SCAN_ADDR: begin
				walk_off = off_q[AW-1:0];
				rd_addr  = slot;
			end
			ST_ATTACH: begin
				wr_addr = slot_q;
				if (out_free) begin
					emit         = 1'b1;
					cmd.attach   = 1'b1;
					res.at_front = (off_q == '0);
					res.last     = 1'b1;
				end
			end
			ST_MISS: begin
				if (out_free) begin
					emit       = 1'b1;
					res.status = STATUS_MISS;
					res.last   = 1'b1;
				end
			end
			ST_NOP: begin
				if (out_free) begin
					emit     = 1'b1;
					res.last = 1'b1;
				end
			end
			ST_DRAIN_CHK: begin
				if (!drain_go && out_free) begin
					emit     = 1'b1;
					res.last = 1'b1;
				end
			end
			ST_DRAIN_OUT: begin
				walk_off = AW'(1);
				if (out_free) begin
					emit                = 1'b1;
					cmd.retire          = 1'b1;
					res.item_valid      = 1'b1;
					res.out_response    = rd_resp;
					res.out_head_method = rd_head;
					res.last            = drain_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			nout_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			if (cmd.enq) count_q <= count_q + CW'(1);
			if (cmd.retire) begin
				front_q <= slot;
				count_q <= count_q - CW'(1);
				nout_q  <= nout_q + NOUT_W'(1);
			end
			if (state_q == ST_IDLE && req_valid) nout_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			key_q  <= req.request_tag[TW-1:0];
			head_q <= req.is_head_method;
			resp_q <= req.response_handle;
			off_q  <= '0;
		end
		if (state_q == ST_SCAN_ADDR) slot_q <= slot;
		if (state_q == ST_SCAN_CMP && !match) off_q <= off_q + CW'(1);
		if (emit) out_q <= res;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hdl/iorq_check.sv =====
// ----------------------------------------------------------------------------
// iorq_check: port-level checks for the in-order response queue
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module iorq_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input iorq_pkg::rsp_t rsp
);
	import iorq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in progress");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_OK |-> rsp.last && !rsp.item_valid && !rsp.at_front)
		else $error("error result not a lone final result");

	a_more_items: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.item_valid && rsp.status == STATUS_OK)
		else $error("non-final result without a drained entry");

endmodule

bind in_order_response_queue iorq_check u_iorq_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
